// ----- rtl/core/plhe_pkg.sv -----
// Shared types and constants for the packet length header encoder.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package plhe_pkg;

	localparam int LenWidth = 32;

	// Partial chunks cover length bits 9 through 30, announced largest first.
	localparam int ChunkLo    = 9;
	localparam int ChunkHi    = 30;
	localparam int ChunkCount = ChunkHi - ChunkLo + 1;
	localparam int ChunkPosW  = $clog2(ChunkCount);
	localparam int ChunkExpW  = $clog2(ChunkHi + 1);

	localparam logic [7:0] HdrOld     = 8'h80;
	localparam logic [7:0] HdrNew     = 8'hc0;
	localparam logic [7:0] HdrPartial = 8'he0;
	localparam logic [7:0] HdrFive    = 8'hff;

	localparam logic [LenWidth-1:0] NewOneMax = 32'd191;
	localparam logic [LenWidth-1:0] NewTwoMax = 32'd8383;
	localparam logic [12:0]         TwoBias   = 13'd192;
	localparam logic [LenWidth-1:0] OldOneMax = 32'd255;
	localparam logic [LenWidth-1:0] OldTwoMax = 32'd65535;
	localparam logic [LenWidth-1:0] PartMin   = 32'd512;

	localparam logic [2:0] ReqOne  = 3'd1;
	localparam logic [2:0] ReqTwo  = 3'd2;
	localparam logic [2:0] ReqFive = 3'd5;

	// Old-format length types in the low two bits of the tag octet.
	localparam logic [1:0] OldTypeOne  = 2'd0;
	localparam logic [1:0] OldTypeTwo  = 2'd1;
	localparam logic [1:0] OldTypeFour = 2'd2;
	localparam logic [1:0] OldTypeOpen = 2'd3;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_SHORT = 2'd1,
		ERR_LONG  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAG,
		ST_CHUNK,
		ST_LEN
	} state_t;

	typedef enum logic [1:0] {
		SEL_TAG,
		SEL_CHUNK,
		SEL_LEN
	} sel_t;

	typedef struct packed {
		logic load;
		logic emit;
		sel_t sel;
		logic last;
		logic chunk_pop;
		logic idx_inc;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic new_format;
		logic partial;
		logic chunk_more;
		logic len_final;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/plhe_if.sv -----
// Valid/ready channel interfaces for request items and header octet results.
// Depends on plhe_pkg for the length width.
`default_nettype none

interface plhe_req_if;
	logic                          valid;
	logic                          ready;
	logic [5:0]                    tag;
	logic [plhe_pkg::LenWidth-1:0] body_length;
	logic                          new_format;
	logic                          partial;
	logic [2:0]                    requested_octets;

	modport source (output valid, tag, body_length, new_format, partial, requested_octets,
		input ready);
	modport sink (input valid, tag, body_length, new_format, partial, requested_octets,
		output ready);
endinterface

interface plhe_oct_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    header_byte;
	logic [plhe_pkg::LenWidth-1:0] data_after;
	logic [1:0]                    error_code;
	logic                          last;

	modport source (output valid, header_byte, data_after, error_code, last, input ready);
	modport sink (input valid, header_byte, data_after, error_code, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/plhe_ctrl.sv -----
// Controller state machine: sequences tag, partial chunk and length octets.
// Depends on plhe_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module plhe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire plhe_pkg::status_t status,
	output plhe_pkg::cmd_t         cmd
);

	plhe_pkg::state_t state_q;
	plhe_pkg::state_t state_d;
	logic             out_valid_q;
	logic             can_emit;

	// A new octet may be loaded when the output register is empty or being drained.
	assign can_emit  = !out_valid_q || out_ready;
	assign req_ready = (state_q == plhe_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plhe_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.sel       = plhe_pkg::SEL_TAG;
		unique case (state_q)
			plhe_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = plhe_pkg::ST_TAG;
				end
			end
			plhe_pkg::ST_TAG: begin
				if (can_emit) begin
					cmd.emit = 1'b1;
					cmd.sel  = plhe_pkg::SEL_TAG;
					if (status.err || (!status.new_format && status.partial)) begin
						cmd.last = 1'b1;
						state_d  = plhe_pkg::ST_IDLE;
					end else if (status.new_format && status.partial) begin
						state_d = plhe_pkg::ST_CHUNK;
					end else begin
						state_d = plhe_pkg::ST_LEN;
					end
				end
			end
			plhe_pkg::ST_CHUNK: begin
				if (can_emit) begin
					cmd.emit      = 1'b1;
					cmd.sel       = plhe_pkg::SEL_CHUNK;
					cmd.chunk_pop = 1'b1;
					if (!status.chunk_more) begin
						state_d = plhe_pkg::ST_LEN;
					end
				end
			end
			plhe_pkg::ST_LEN: begin
				if (can_emit) begin
					cmd.emit    = 1'b1;
					cmd.sel     = plhe_pkg::SEL_LEN;
					cmd.idx_inc = 1'b1;
					if (status.len_final) begin
						cmd.last = 1'b1;
						state_d  = plhe_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = plhe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/plhe_dp.sv -----
// Datapath: request registers, chunk mask, length octet builder and output register.
// Depends on plhe_pkg; controlled by plhe_ctrl through cmd_t.
`default_nettype none

module plhe_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire plhe_pkg::cmd_t                cmd,
	output plhe_pkg::status_t                  status,
	input  wire logic [5:0]                    tag,
	input  wire logic [plhe_pkg::LenWidth-1:0] body_length,
	input  wire logic                          new_format,
	input  wire logic                          partial,
	input  wire logic [2:0]                    requested_octets,
	output logic [7:0]                         header_byte,
	output logic [plhe_pkg::LenWidth-1:0]      data_after,
	output logic [1:0]                         error_code,
	output logic                               last
);

	localparam int LW = plhe_pkg::LenWidth;
	localparam int CN = plhe_pkg::ChunkCount;

	logic [5:0]                     tag_q;
	logic [LW-1:0]                  len_q;
	logic                           newf_q;
	logic                           part_q;
	logic [2:0]                     req_q;
	logic [CN-1:0]                  mask_q;
	logic [2:0]                     idx_q;

	logic [7:0]                     byte_q;
	logic [LW-1:0]                  after_q;
	logic [1:0]                     err_q;
	logic                           last_q;

	plhe_pkg::err_t                 err;
	logic [LW-1:0]                  enc_v;
	logic [12:0]                    bias;
	logic [2:0]                     nlen;
	logic [39:0]                    lbytes;
	logic [1:0]                     old_type;
	logic [plhe_pkg::ChunkPosW-1:0] pos;
	logic [CN-1:0]                  top_oh;
	logic [plhe_pkg::ChunkExpW-1:0] chunk_exp;
	logic [7:0]                     tag_byte;
	logic [7:0]                     len_byte;
	logic [7:0]                     sel_byte;
	logic [LW-1:0]                  sel_after;

	// Mode flags and the chunk mask are control state; the rest is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newf_q <= 1'b0;
			part_q <= 1'b0;
			mask_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				newf_q <= new_format;
				part_q <= partial;
				mask_q <= body_length[plhe_pkg::ChunkHi:plhe_pkg::ChunkLo];
				idx_q  <= '0;
			end else begin
				if (cmd.chunk_pop) begin
					mask_q <= mask_q & ~top_oh;
				end
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q <= tag;
			len_q <= body_length;
			req_q <= requested_octets;
		end
		if (cmd.emit) begin
			byte_q  <= sel_byte;
			after_q <= sel_after;
			err_q   <= (cmd.sel == plhe_pkg::SEL_TAG) ? err : plhe_pkg::ERR_NONE;
			last_q  <= cmd.last;
		end
	end

	always_comb begin
		if (newf_q && part_q && (len_q < plhe_pkg::PartMin)) begin
			err = plhe_pkg::ERR_SHORT;
		end else if (newf_q && part_q && len_q[LW-1]) begin
			err = plhe_pkg::ERR_LONG;
		end else begin
			err = plhe_pkg::ERR_NONE;
		end
	end

	// The final piece of a partial body is the length modulo 512.
	assign enc_v = (newf_q && part_q) ? {{(LW-9){1'b0}}, len_q[8:0]} : len_q;
	assign bias  = enc_v[12:0] - plhe_pkg::TwoBias;

	always_comb begin
		if (newf_q) begin
			if (!part_q && (req_q == plhe_pkg::ReqFive)) begin
				nlen = 3'd5;
			end else if (enc_v <= plhe_pkg::NewOneMax) begin
				nlen = 3'd1;
			end else if (enc_v <= plhe_pkg::NewTwoMax) begin
				nlen = 3'd2;
			end else begin
				nlen = 3'd5;
			end
		end else begin
			if ((req_q == plhe_pkg::ReqOne) && (len_q <= plhe_pkg::OldOneMax)) begin
				nlen = 3'd1;
			end else if ((req_q == plhe_pkg::ReqTwo) && (len_q <= plhe_pkg::OldTwoMax)) begin
				nlen = 3'd2;
			end else if (req_q == plhe_pkg::ReqFive) begin
				nlen = 3'd4;
			end else if (len_q <= plhe_pkg::OldOneMax) begin
				nlen = 3'd1;
			end else if (len_q <= plhe_pkg::OldTwoMax) begin
				nlen = 3'd2;
			end else begin
				nlen = 3'd4;
			end
		end
	end

	// Length octets, left aligned in transmission order.
	always_comb begin
		unique case (nlen)
			3'd1:    lbytes = {enc_v[7:0], 32'd0};
			3'd2:    lbytes = newf_q ? {plhe_pkg::HdrNew | {3'd0, bias[12:8]}, bias[7:0], 24'd0}
			                         : {len_q[15:8], len_q[7:0], 24'd0};
			3'd4:    lbytes = {len_q, 8'd0};
			default: lbytes = {plhe_pkg::HdrFive, len_q};
		endcase
		unique case (nlen)
			3'd1:    old_type = plhe_pkg::OldTypeOne;
			3'd2:    old_type = plhe_pkg::OldTypeTwo;
			default: old_type = plhe_pkg::OldTypeFour;
		endcase
	end

	always_comb begin
		unique case (idx_q)
			3'd0:    len_byte = lbytes[39:32];
			3'd1:    len_byte = lbytes[31:24];
			3'd2:    len_byte = lbytes[23:16];
			3'd3:    len_byte = lbytes[15:8];
			default: len_byte = lbytes[7:0];
		endcase
	end

	// Highest remaining chunk bit.
	always_comb begin
		pos = '0;
		for (int i = 0; i < CN; i++) begin
			if (mask_q[i]) begin
				pos = plhe_pkg::ChunkPosW'(i);
			end
		end
	end

	assign top_oh    = CN'(1) << pos;
	assign chunk_exp = plhe_pkg::ChunkExpW'(pos) + plhe_pkg::ChunkExpW'(plhe_pkg::ChunkLo);

	assign tag_byte = newf_q
		? (plhe_pkg::HdrNew | {2'd0, tag_q})
		: (plhe_pkg::HdrOld | {2'd0, tag_q[3:0], 2'd0}
			| {6'd0, part_q ? plhe_pkg::OldTypeOpen : old_type});

	always_comb begin
		unique case (cmd.sel)
			plhe_pkg::SEL_TAG: begin
				if (err != plhe_pkg::ERR_NONE) begin
					sel_byte  = 8'd0;
					sel_after = '0;
				end else begin
					sel_byte  = tag_byte;
					sel_after = (!newf_q && part_q) ? len_q : '0;
				end
			end
			plhe_pkg::SEL_CHUNK: begin
				sel_byte  = plhe_pkg::HdrPartial | {3'd0, chunk_exp};
				sel_after = LW'(1) << chunk_exp;
			end
			default: begin
				sel_byte  = len_byte;
				sel_after = (idx_q == nlen - 3'd1) ? enc_v : '0;
			end
		endcase
	end

	assign status.err        = (err != plhe_pkg::ERR_NONE);
	assign status.new_format = newf_q;
	assign status.partial    = part_q;
	assign status.chunk_more = |(mask_q & ~top_oh);
	assign status.len_final  = (idx_q == nlen - 3'd1);

	assign header_byte = byte_q;
	assign data_after  = after_q;
	assign error_code  = err_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/packet_length_header_encoder_core.sv -----
// Packet length header encoder, top level.
//
// A request transfer on the request channel carries a tag, a body length, the
// header format, a partial flag and a preferred length octet count. The block
// answers with one header octet per transfer on the octet channel, in
// transmission order, the final one marked by last. Each octet also carries
// data_after, the number of body octets the sender copies before the next
// header octet. A rejected partial request yields one zero octet with an
// error code.
//
// Timing: the request transfer loads the request registers, and the first
// octet then enters the output register; one octet follows per cycle while
// the receiver keeps ready high. A request yields 1 to 25 octets; the
// controller works on one request at a time, and the next request is
// taken as soon as the final octet sits in the output register.
// When the receiver stalls, the output register holds its octet and the
// controller waits. Reset clears the controller and the output valid flag.
`default_nettype none

module packet_length_header_encoder_core (
	input  wire logic clk,
	input  wire logic arst_n,
	plhe_req_if.sink  request,
	plhe_oct_if.source octet
);

	plhe_pkg::cmd_t    cmd;
	plhe_pkg::status_t status;

	plhe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.out_valid (octet.valid),
		.out_ready (octet.ready),
		.status    (status),
		.cmd       (cmd)
	);

	plhe_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.tag              (request.tag),
		.body_length      (request.body_length),
		.new_format       (request.new_format),
		.partial          (request.partial),
		.requested_octets (request.requested_octets),
		.header_byte      (octet.header_byte),
		.data_after       (octet.data_after),
		.error_code       (octet.error_code),
		.last             (octet.last)
	);

endmodule

`default_nettype wire

// ----- rtl/core/plhe_checker.sv -----
// Port-level checker for the packet length header encoder, with its bind.
// Depends on plhe_pkg and on the ports of packet_length_header_encoder_core.
`default_nettype none

module plhe_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [7:0]                    out_byte,
	input wire logic [plhe_pkg::LenWidth-1:0] out_after,
	input wire logic [1:0]                    out_err,
	input wire logic                          out_last
);

	logic [1:0] pend_q;
	logic       req_xfer;
	logic       fin_xfer;

	assign req_xfer = req_valid && req_ready;
	assign fin_xfer = out_valid && out_ready && out_last;

	// Requests taken whose final octet has not been transferred yet. A second
	// request can be taken while the final octet of the first still waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(req_xfer) - 2'(fin_xfer);
		end
	end

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_err != 2'(plhe_pkg::ERR_NONE))
			|-> (out_byte == 8'd0) && (out_after == '0) && out_last)
		else $error("error octet is not a single zero octet");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |-> (pend_q == 2'd0) || ((pend_q == 2'd1) && out_valid && out_last))
		else $error("request taken while an earlier request is still being encoded");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("octet presented with no request outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_after)
			&& $stable(out_err) && $stable(out_last))
		else $error("stalled octet changed");

endmodule

bind packet_length_header_encoder_core plhe_checker u_plhe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.out_valid (octet.valid),
	.out_ready (octet.ready),
	.out_byte  (octet.header_byte),
	.out_after (octet.data_after),
	.out_err   (octet.error_code),
	.out_last  (octet.last)
);

`default_nettype wire

// ----- tb/sv/plhe_header_checker.sv -----
// Checker for the packet length header encoder: watches the request and octet channels,
// predicts the header octets of every request and compares them in order.
// Depends on plhe_pkg and the channel interfaces in plhe_if.
`default_nettype none

module plhe_header_checker
	import plhe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	plhe_req_if  request,
	plhe_oct_if  octet,
	output int   mismatches,
	output int   outstanding,
	output int   requests_seen,
	output int   octets_seen,
	output int   errors_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]          hbyte;
		logic [LenWidth-1:0] after;
		err_t                err;
		logic                last;
	} hdr_octet_t;

	hdr_octet_t header_queue[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
		requests_seen = 0;
		octets_seen = 0;
		errors_seen = 0;
	end

	function automatic void queue_octet(input logic [7:0] b, input logic [LenWidth-1:0] after,
			input err_t err, input logic fin);
		hdr_octet_t o;
		o.hbyte = b;
		o.after = after;
		o.err = err;
		o.last = fin;
		header_queue.push_back(o);
	endfunction

	// Length octets most significant first; only the final one announces body data.
	function automatic void queue_big_endian(input logic [LenWidth-1:0] n, input int count);
		int i;
		for (i = count - 1; i >= 0; i--)
			queue_octet(n[8*i +: 8], (i == 0) ? n : '0, ERR_NONE, i == 0);
	endfunction

	// New-format one or two octet length, picked by the value alone.
	function automatic void queue_short_length(input logic [LenWidth-1:0] n, input logic fin);
		logic [LenWidth-1:0] v;
		if (n <= NewOneMax) begin
			queue_octet(n[7:0], n, ERR_NONE, fin);
		end else begin
			v = n - LenWidth'(TwoBias);
			queue_octet(HdrNew + v[15:8], '0, ERR_NONE, 1'b0);
			queue_octet(v[7:0], n, ERR_NONE, fin);
		end
	endfunction

	function automatic void frame_header(input logic [5:0] tag, input logic [LenWidth-1:0] len,
			input logic newf, input logic part, input logic [2:0] req);
		int          nbytes;
		int          i;
		logic [7:0]  hdr;
		logic [1:0]  typ;
		if (!newf) begin
			hdr = HdrOld | {2'b00, tag[3:0], 2'b00};
			if (part) begin
				queue_octet(hdr | {6'b0, OldTypeOpen}, len, ERR_NONE, 1'b1);
				return;
			end
			if (req == ReqOne && len <= OldOneMax)
				nbytes = 1;
			else if (req == ReqTwo && len <= OldTwoMax)
				nbytes = 2;
			else if (req == ReqFive)
				nbytes = 4;
			else if (len <= OldOneMax)
				nbytes = 1;
			else if (len <= OldTwoMax)
				nbytes = 2;
			else
				nbytes = 4;
			typ = (nbytes == 1) ? OldTypeOne : (nbytes == 2) ? OldTypeTwo : OldTypeFour;
			queue_octet(hdr | {6'b0, typ}, '0, ERR_NONE, 1'b0);
			queue_big_endian(len, nbytes);
		end else if (part) begin
			if (len < PartMin) begin
				queue_octet('0, '0, ERR_SHORT, 1'b1);
			end else if (len[LenWidth-1]) begin
				queue_octet('0, '0, ERR_LONG, 1'b1);
			end else begin
				queue_octet(HdrNew | {2'b00, tag}, '0, ERR_NONE, 1'b0);
				for (i = ChunkHi; i >= ChunkLo; i--)
					if (len[i])
						queue_octet(HdrPartial | 8'(i), LenWidth'(1) << i, ERR_NONE, 1'b0);
				// The remainder below 512 closes the packet without a repeated tag.
				queue_short_length(len & LenWidth'(511), 1'b1);
			end
		end else begin
			queue_octet(HdrNew | {2'b00, tag}, '0, ERR_NONE, 1'b0);
			// A one or two octet request that does not fit ends up on the same
			// encoding the value would get anyway, so only five octets is special.
			if (req == ReqFive || len > NewTwoMax) begin
				queue_octet(HdrFive, '0, ERR_NONE, 1'b0);
				queue_big_endian(len, 4);
			end else begin
				queue_short_length(len, 1'b1);
			end
		end
	endfunction

	function automatic void report_mismatch(input hdr_octet_t want, input hdr_octet_t got,
			input logic orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("%0t: octet with nothing expected: byte %02h after %0d err %0d last %0b",
					$realtime, got.hbyte, got.after, got.err, got.last);
			else
				$display("%0t: octet mismatch: expected byte %02h after %0d err %0d last %0b, %s",
					$realtime, want.hbyte, want.after, want.err, want.last,
					$sformatf("got byte %02h after %0d err %0d last %0b",
						got.hbyte, got.after, got.err, got.last));
		end
	endfunction

	always @(posedge clk) begin
		hdr_octet_t got;
		hdr_octet_t want;
		if (arst_n) begin
			if (octet.valid && octet.ready) begin
				got.hbyte = octet.header_byte;
				got.after = octet.data_after;
				got.err = err_t'(octet.error_code);
				got.last = octet.last;
				octets_seen++;
				if (got.err != ERR_NONE)
					errors_seen++;
				if (header_queue.size() == 0) begin
					want = '0;
					report_mismatch(want, got, 1'b1);
				end else begin
					want = header_queue.pop_front();
					if (got !== want)
						report_mismatch(want, got, 1'b0);
				end
			end
			if (request.valid && request.ready) begin
				requests_seen++;
				frame_header(request.tag, request.body_length, request.new_format,
					request.partial, request.requested_octets);
			end
			outstanding = header_queue.size();
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Top of the packet length header encoder testbench: clock, reset, request stimulus
// and receiver back-pressure, with plhe_header_checker doing prediction and comparison.
// Depends on plhe_pkg, plhe_if, plhe_header_checker and packet_length_header_encoder_core.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plhe_pkg::*;

	localparam int RandomItems = 370;
	localparam int LongStall   = 400;
	localparam int DrainCycles = 64;

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle = 1'b0;
	bit   stall_req = 1'b0;
	int   mismatches;
	int   outstanding;
	int   requests_seen;
	int   octets_seen;
	int   errors_seen;

	plhe_req_if request ();
	plhe_oct_if octet ();

	packet_length_header_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.octet  (octet)
	);

	plhe_header_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.octet        (octet),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.requests_seen(requests_seen),
		.octets_seen  (octets_seen),
		.errors_seen  (errors_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_request(input logic [5:0] tag, input logic [LenWidth-1:0] len,
			input logic newf, input logic part, input logic [2:0] req);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request.valid <= 1'b1;
		request.tag <= tag;
		request.body_length <= len;
		request.new_format <= newf;
		request.partial <= part;
		request.requested_octets <= req;
		do @(posedge clk); while (!request.ready);
		@(negedge clk);
	endtask

	function automatic logic [LenWidth-1:0] pick_length();
		int unsigned borders [10] = '{191, 192, 255, 256, 511, 512, 8383, 8384, 65535, 65536};
		logic [LenWidth-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 400);
			1: v = borders[$urandom_range(0, 9)] + $urandom_range(0, 4) - 2;
			2: v = $urandom;
			3: v = $urandom_range(8384, 70000);
			4: v = $urandom >> $urandom_range(1, 22);
			default: v = $urandom_range(0, 1023);
		endcase
		return v;
	endfunction

	// Receiver: random stalls per octet, one long hold-off on request, none in quiet phases.
	initial begin
		int w;
		octet.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				octet.ready <= 1'b0;
				repeat (LongStall) @(negedge clk);
			end
			w = no_idle ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				octet.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			octet.ready <= 1'b1;
			do @(posedge clk); while (!octet.valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		request.valid = 1'b0;
		request.tag = '0;
		request.body_length = '0;
		request.new_format = 1'b0;
		request.partial = 1'b0;
		request.requested_octets = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Old format: each length size, fallbacks to automatic, indeterminate length.
		offer_request(6'd0, 32'd0, 1'b0, 1'b0, ReqOne);
		offer_request(6'd63, 32'd255, 1'b0, 1'b0, ReqOne);
		offer_request(6'd5, 32'd256, 1'b0, 1'b0, ReqOne);
		offer_request(6'd10, 32'd65535, 1'b0, 1'b0, ReqTwo);
		offer_request(6'd17, 32'd65536, 1'b0, 1'b0, ReqTwo);
		offer_request(6'd2, 32'd7, 1'b0, 1'b0, ReqFive);
		offer_request(6'd48, 32'hffff_ffff, 1'b0, 1'b0, 3'd0);
		offer_request(6'd31, 32'd300, 1'b0, 1'b0, 3'd3);
		offer_request(6'd42, 32'd1234, 1'b0, 1'b1, 3'd7);
		// New format: fixed sizes, sizes that do not fit, five octets.
		offer_request(6'd1, 32'd191, 1'b1, 1'b0, ReqOne);
		offer_request(6'd2, 32'd192, 1'b1, 1'b0, ReqOne);
		offer_request(6'd3, 32'd100, 1'b1, 1'b0, ReqTwo);
		offer_request(6'd4, 32'd192, 1'b1, 1'b0, ReqTwo);
		offer_request(6'd63, 32'd8383, 1'b1, 1'b0, ReqTwo);
		offer_request(6'd6, 32'd8384, 1'b1, 1'b0, ReqTwo);
		offer_request(6'd0, 32'd0, 1'b1, 1'b0, ReqFive);
		offer_request(6'd7, 32'hffff_ffff, 1'b1, 1'b0, 3'd4);
		offer_request(6'd8, 32'd8384, 1'b1, 1'b0, 3'd6);
		// New-format partial: both errors at their borders, fewest and most chunks.
		offer_request(6'd9, 32'd0, 1'b1, 1'b1, 3'd0);
		offer_request(6'd9, 32'd511, 1'b1, 1'b1, ReqOne);
		offer_request(6'd11, 32'd512, 1'b1, 1'b1, ReqTwo);
		offer_request(6'd63, 32'h7fff_ffff, 1'b1, 1'b1, ReqFive);
		offer_request(6'd12, 32'h8000_0000, 1'b1, 1'b1, 3'd0);
		offer_request(6'd13, 32'hffff_ffff, 1'b1, 1'b1, 3'd0);
		offer_request(6'd14, 32'd1215, 1'b1, 1'b1, 3'd0);

		for (int n = 0; n < RandomItems; n++) begin
			logic newf;
			logic part;
			logic [LenWidth-1:0] len;
			logic [LenWidth-1:0] v;
			if (n == 120)
				stall_req = 1'b1;
			no_idle = (n >= 220 && n < 300);
			newf = 1'($urandom_range(0, 1));
			part = ($urandom_range(0, 2) == 0);
			if (newf && part && $urandom_range(0, 9) != 0) begin
				// Mostly lengths that pass the partial checks.
				v = $urandom >> $urandom_range(1, 22);
				len = (v < PartMin) ? v + PartMin : v;
			end else begin
				len = pick_length();
			end
			offer_request(6'($urandom_range(0, 63)), len, newf, part,
				3'($urandom_range(0, 7)));
		end
		request.valid <= 1'b0;
		no_idle = 1'b0;

		wait (outstanding == 0);
		repeat (DrainCycles) @(posedge clk);
		$display("Framed %0d requests into %0d header octets, %0d of them error responses.",
			requests_seen, octets_seen, errors_seen);
		$display("Old and new formats, partial chunking and back-pressure with a long stall.");
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
